@@ design/edf_unit_task_scheduler_unit_defines.svh @@
// Assertion macros used by the scheduler datapath module.
`ifndef EDF_UNIT_TASK_SCHEDULER_UNIT_DEFINES_SVH
`define EDF_UNIT_TASK_SCHEDULER_UNIT_DEFINES_SVH

`ifndef SYNTH
`define EDFTS_ASSERT_IMPL(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error("scheduler assertion violated");
`define EDFTS_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error("scheduler assertion violated");
`else
`define EDFTS_ASSERT_IMPL(lbl, ck, rn, ante, cons)
`define EDFTS_ASSERT_NEXT(lbl, ck, rn, ante, cons)
`endif

`endif

@@ design/edfts_pkg.sv @@
package edfts_pkg;

	localparam int MAX_JOBS  = 16;
	localparam int DAY_WIDTH = 16;
	localparam int IDX_W     = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
	localparam int CNT_W     = $clog2(MAX_JOBS + 1);

	localparam int OP_W    = 2;
	localparam int ID_W    = 8;
	localparam int DL_W    = 16;
	localparam int UNITS_W = 16;
	localparam int OC_W    = 3;
	localparam int CMP_W   = (DL_W > DAY_WIDTH + 1) ? DL_W : DAY_WIDTH + 1;

	localparam int IN_FIELDS_W = ID_W + DL_W + UNITS_W + 1;
	localparam int IN_DATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
	localparam int OUT_DATA_W  = ID_W;

	localparam logic [OP_W-1:0] OP_RELEASE = OP_W'(0);
	localparam logic [OP_W-1:0] OP_TICK    = OP_W'(1);
	localparam logic [OP_W-1:0] OP_FINISH  = OP_W'(2);

	typedef enum logic [OC_W-1:0] {
		OC_RELEASED,
		OC_FULL,
		OC_IDLE,
		OC_WORKED,
		OC_BLOCKED,
		OC_MISSED,
		OC_FIN_OK,
		OC_FIN_FAIL
	} outcome_t;

	typedef struct packed {
		logic [ID_W-1:0]    id;
		logic [DL_W-1:0]    deadline;
		logic [UNITS_W-1:0] remaining;
	} entry_t;

	typedef struct packed {
		logic latch;
		logic rel_exec;
		logic tick_exec;
		logic scan;
		logic decide;
		logic fin_exec;
		logic emit;
	} ctl_cmd_t;

	typedef struct packed {
		logic blocked;
		logic scan_done;
		logic out_free;
	} ctl_sts_t;

endpackage

@@ design/edfts_ram.sv @@
module edfts_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

@@ design/edfts_ctrl.sv @@
module edfts_ctrl (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_tvalid,
	input  logic [edfts_pkg::OP_W-1:0]  opcode,
	output logic                        s_tready,
	output edfts_pkg::ctl_cmd_t         cmd,
	input  edfts_pkg::ctl_sts_t         sts
);
	import edfts_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_REL,
		ST_TICK,
		ST_SCAN,
		ST_DECIDE,
		ST_FIN,
		ST_RESP
	} state_t;

	state_t state_q;

	always_comb begin
		cmd      = '0;
		s_tready = (state_q == ST_IDLE);
		case (state_q)
			ST_IDLE:   cmd.latch     = s_tvalid;
			ST_REL:    cmd.rel_exec  = 1'b1;
			ST_TICK:   cmd.tick_exec = 1'b1;
			ST_SCAN:   cmd.scan      = 1'b1;
			ST_DECIDE: cmd.decide    = 1'b1;
			ST_FIN:    cmd.fin_exec  = 1'b1;
			ST_RESP:   cmd.emit      = sts.out_free;
			default:   cmd           = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						case (opcode)
							OP_RELEASE: state_q <= ST_REL;
							OP_TICK:    state_q <= ST_TICK;
							OP_FINISH:  state_q <= ST_FIN;
							default:    state_q <= ST_IDLE;
						endcase
					end
				end
				ST_REL:    state_q <= ST_RESP;
				ST_TICK:   state_q <= sts.blocked ? ST_RESP : ST_SCAN;
				ST_SCAN: begin
					if (sts.scan_done) begin
						state_q <= ST_DECIDE;
					end
				end
				ST_DECIDE: state_q <= ST_RESP;
				ST_FIN:    state_q <= ST_RESP;
				ST_RESP: begin
					if (sts.out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default:   state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

@@ design/edfts_dp.sv @@
`include "edf_unit_task_scheduler_unit_defines.svh"

module edfts_dp (
	input  logic                             clk,
	input  logic                             arst_n,
	input  edfts_pkg::ctl_cmd_t              cmd,
	output edfts_pkg::ctl_sts_t              sts,
	input  logic [edfts_pkg::IN_DATA_W-1:0]  in_data,
	input  logic                             m_tready,
	output logic                             m_tvalid,
	output logic [edfts_pkg::OUT_DATA_W-1:0] m_tdata,
	output logic [edfts_pkg::OC_W-1:0]       m_tuser
);
	import edfts_pkg::*;

	localparam int DL_LSB  = ID_W;
	localparam int UN_LSB  = ID_W + DL_W;
	localparam int BLK_BIT = ID_W + DL_W + UNITS_W;

	logic [ID_W-1:0]      id_q;
	logic [DL_W-1:0]      dl_q;
	logic [UNITS_W-1:0]   units_q;
	logic                 blk_q;

	logic [MAX_JOBS-1:0]  valid_q;
	logic [DAY_WIDTH-1:0] day_q;
	logic [CMP_W-1:0]     today_q;
	logic                 failed_q;

	logic [CNT_W-1:0]     cnt_q;
	logic                 cmp_vld_s1;
	logic [IDX_W-1:0]     cmp_idx_s1;

	logic                 best_found_q;
	logic [IDX_W-1:0]     best_idx_q;
	logic [ID_W-1:0]      best_id_q;
	logic [DL_W-1:0]      best_dl_q;
	logic [UNITS_W-1:0]   best_rem_q;

	outcome_t             res_oc_q;
	logic [ID_W-1:0]      res_id_q;
	logic                 out_valid_q;
	outcome_t             out_oc_q;
	logic [ID_W-1:0]      out_id_q;

	logic                 free_found;
	logic [IDX_W-1:0]     free_idx;
	logic                 issue;
	logic                 take;
	logic                 missed;
	logic                 rel_store;
	logic                 ram_we;
	logic [IDX_W-1:0]     ram_waddr;
	entry_t               ram_wdata;
	entry_t               rd_entry;

	always_comb begin
		free_found = 1'b0;
		free_idx   = '0;
		for (int k = MAX_JOBS - 1; k >= 0; k--) begin
			if (!valid_q[k]) begin
				free_found = 1'b1;
				free_idx   = IDX_W'(k);
			end
		end
	end

	assign issue     = cmd.scan && (cnt_q < CNT_W'(MAX_JOBS));
	assign take      = cmp_vld_s1 && valid_q[cmp_idx_s1]
		&& (!best_found_q || (rd_entry.deadline < best_dl_q));
	assign missed    = CMP_W'(best_dl_q) < today_q;
	assign rel_store = cmd.rel_exec && (units_q != '0) && free_found;

	always_comb begin
		ram_we              = rel_store;
		ram_waddr           = free_idx;
		ram_wdata.id        = id_q;
		ram_wdata.deadline  = dl_q;
		ram_wdata.remaining = units_q;
		if (cmd.decide && best_found_q && !missed) begin
			ram_we              = 1'b1;
			ram_waddr           = best_idx_q;
			ram_wdata.id        = best_id_q;
			ram_wdata.deadline  = best_dl_q;
			ram_wdata.remaining = best_rem_q - UNITS_W'(1);
		end
	end

	edfts_ram #(
		.WIDTH($bits(entry_t)),
		.DEPTH(MAX_JOBS)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (cnt_q[IDX_W-1:0]),
		.rdata (rd_entry)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q      <= '0;
			day_q        <= '0;
			failed_q     <= 1'b0;
			cnt_q        <= '0;
			cmp_vld_s1   <= 1'b0;
			best_found_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			cmp_vld_s1 <= issue;
			if (issue) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end
			if (take) begin
				best_found_q <= 1'b1;
			end
			if (cmd.tick_exec) begin
				cnt_q        <= '0;
				best_found_q <= 1'b0;
				if (day_q != '1) begin
					day_q <= day_q + DAY_WIDTH'(1);
				end
			end
			if (rel_store) begin
				valid_q[free_idx] <= 1'b1;
			end
			if (cmd.rel_exec && (units_q != '0) && !free_found) begin
				failed_q <= 1'b1;
			end
			if (cmd.decide && best_found_q) begin
				if (missed) begin
					failed_q <= 1'b1;
				end else if (best_rem_q == UNITS_W'(1)) begin
					valid_q[best_idx_q] <= 1'b0;
				end
			end
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			id_q    <= in_data[ID_W-1:0];
			dl_q    <= in_data[DL_LSB +: DL_W];
			units_q <= in_data[UN_LSB +: UNITS_W];
			blk_q   <= in_data[BLK_BIT];
		end
		cmp_idx_s1 <= cnt_q[IDX_W-1:0];
		if (take) begin
			best_idx_q <= cmp_idx_s1;
			best_id_q  <= rd_entry.id;
			best_dl_q  <= rd_entry.deadline;
			best_rem_q <= rd_entry.remaining;
		end
		if (cmd.tick_exec) begin
			today_q  <= CMP_W'(day_q) + CMP_W'(1);
			res_oc_q <= OC_BLOCKED;
			res_id_q <= '0;
		end
		if (cmd.rel_exec) begin
			res_oc_q <= ((units_q == '0) || free_found) ? OC_RELEASED : OC_FULL;
			res_id_q <= '0;
		end
		if (cmd.fin_exec) begin
			res_oc_q <= ((valid_q == '0) && !failed_q) ? OC_FIN_OK : OC_FIN_FAIL;
			res_id_q <= '0;
		end
		if (cmd.decide) begin
			if (!best_found_q) begin
				res_oc_q <= OC_IDLE;
				res_id_q <= '0;
			end else if (missed) begin
				res_oc_q <= OC_MISSED;
				res_id_q <= '0;
			end else begin
				res_oc_q <= OC_WORKED;
				res_id_q <= best_id_q;
			end
		end
		if (cmd.emit) begin
			out_oc_q <= res_oc_q;
			out_id_q <= res_id_q;
		end
	end

	assign sts.blocked   = blk_q;
	assign sts.scan_done = (cnt_q == CNT_W'(MAX_JOBS)) && !cmp_vld_s1;
	assign sts.out_free  = !out_valid_q || m_tready;

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_id_q;
	assign m_tuser  = out_oc_q;

	`EDFTS_ASSERT_NEXT(a_failed_sticky, clk, arst_n, failed_q, failed_q)
	`EDFTS_ASSERT_NEXT(a_day_nonzero, clk, arst_n, cmd.tick_exec, day_q != '0)
	`EDFTS_ASSERT_IMPL(a_emit_free, clk, arst_n, cmd.emit, !out_valid_q || m_tready)
	`EDFTS_ASSERT_IMPL(a_id_only_worked, clk, arst_n,
		out_valid_q && (out_oc_q != OC_WORKED), out_id_q == '0)
	`EDFTS_ASSERT_IMPL(a_scan_no_write, clk, arst_n, cmd.scan, !ram_we)

endmodule

@@ design/edf_unit_task_scheduler_unit.sv @@
// Release, finish and blocked-day tick: after acceptance the word passes its execute state, and
// ST_RESP then loads the result into the output register once it is free. Free-day tick: ST_SCAN
// reads the 16 table entries one per cycle from a RAM with registered read, then ST_DECIDE, ST_RESP.
// One word is handled at a time, and a word with the unused opcode is dropped on acceptance.
// The next input word is accepted the cycle after the result enters the output register.
// arst_n clears the valid bits, day count, failure flag and control; table data needs no clearing.
module edf_unit_task_scheduler_unit (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	// job_id [7:0], deadline_day [23:8], work_units [39:24], blocked_day [40], zero pad
	input  logic [edfts_pkg::IN_DATA_W-1:0]  s_tdata,
	// opcode [1:0]
	input  logic [edfts_pkg::OP_W-1:0]       s_tuser,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// served_id [7:0]
	output logic [edfts_pkg::OUT_DATA_W-1:0] m_tdata,
	// outcome [2:0]
	output logic [edfts_pkg::OC_W-1:0]       m_tuser
);
	import edfts_pkg::*;

	ctl_cmd_t cmd;
	ctl_sts_t sts;

	edfts_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.opcode   (s_tuser),
		.s_tready (s_tready),
		.cmd      (cmd),
		.sts      (sts)
	);

	edfts_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.sts      (sts),
		.in_data  (s_tdata),
		.m_tready (m_tready),
		.m_tvalid (m_tvalid),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

endmodule
